[rtl/core/bsws_pkg.sv]
// ----------------------------------------------------------------------------
// bsws_pkg
// Shared types, codes and helpers for the whole-word byte substring search.
// ----------------------------------------------------------------------------
package bsws_pkg;

  // Input word command codes.
  typedef enum logic {
    CMD_BYTE      = 1'b0,
    CMD_FOLD_LOAD = 1'b1
  } cmd_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENSITIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORDS    = 3'd4;

  localparam int FOLD_DEPTH = 256;
  localparam logic [7:0] UNDERSCORE = 8'h5F;

  // Read and write requests toward the fold table.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } fold_rd_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } fold_wr_t;

  // ASCII letter, digit or underscore.
  function automatic logic is_word_byte(input logic [7:0] c);
    logic res;
    res = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
          ((c >= 8'h61) && (c <= 8'h7A)) || (c == UNDERSCORE);
    return res;
  endfunction

endpackage

[rtl/core/bsws_fold_mem.sv]
// ----------------------------------------------------------------------------
// bsws_fold_mem
// 256-entry fold table with one synchronous read port and one write port.
// Entries never written read as their own index.
// ----------------------------------------------------------------------------
module bsws_fold_mem
  import bsws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fold_rd_t   rd,
  input  fold_wr_t   wr,
  output logic [7:0] rd_data
);

  logic [7:0]            mem [FOLD_DEPTH];
  logic [FOLD_DEPTH-1:0] vld_r;
  logic [7:0]            mem_q_r;
  logic [7:0]            addr_q_r;
  logic                  vld_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      mem_q_r  <= mem[rd.addr];
      addr_q_r <= rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (rd.en) begin
        vld_q_r <= vld_r[rd.addr];
      end
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : addr_q_r;

endmodule

[rtl/core/byte_substring_whole_word_search.sv]
// ----------------------------------------------------------------------------
// byte_substring_whole_word_search
// Streams content bytes and reports the offset of the first occurrence of a
// needle, with optional case folding and whole-word filtering.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_ready   in_cmd, in_byte_value, in_fold_index,
//                                   in_is_last
// out      out  out_valid/out_ready out_found, out_match_offset
// cfg      in   cfg_we              cfg_index, cfg_wdata
//
// One input word per cycle while in_ready is high. A content byte reads the
// fold table on accept and is compared in the compare stage; its result is
// registered when that stage fires. A write to either needle register refreshes
// the folded needle through the single table read port, with in_ready low until
// every needle byte is written back. Reset needs no clearing pass; unwritten
// table entries read as identity. Apart from that refresh, in_ready drops
// only while a compare word waits behind a stalled result.
// ----------------------------------------------------------------------------
module byte_substring_whole_word_search
  import bsws_pkg::*;
#(
  parameter int MAX_NEEDLE  = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [7:0]            in_byte_value,
  input  logic [7:0]            in_fold_index,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [31:0]           out_match_offset,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
  localparam int NI_W  = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int EXT_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  // Configuration registers.
  logic [63:0] needle_low_r;
  logic [63:0] needle_high_r;
  logic [4:0]  needle_length_r;
  logic        case_sensitive_r;
  logic        whole_words_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_low_r     <= '0;
      needle_high_r    <= '0;
      needle_length_r  <= '0;
      case_sensitive_r <= 1'b1;
      whole_words_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEEDLE_LOW:     needle_low_r     <= cfg_wdata;
        CFG_NEEDLE_HIGH:    needle_high_r    <= cfg_wdata;
        CFG_NEEDLE_LENGTH:  needle_length_r  <= cfg_wdata[4:0];
        CFG_CASE_SENSITIVE: case_sensitive_r <= cfg_wdata[0];
        CFG_WHOLE_WORDS:    whole_words_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Raw needle bytes; positions past the two registers read as zero.
  logic [7:0] raw_needle [MAX_NEEDLE];

  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_needle
    if (k < 8) begin : g_low
      assign raw_needle[k] = needle_low_r[8*k +: 8];
    end else if (k < 16) begin : g_high
      assign raw_needle[k] = needle_high_r[8*(k-8) +: 8];
    end else begin : g_zero
      assign raw_needle[k] = 8'h00;
    end
  end

  logic [LEN_W-1:0] len_c;

  always_comb begin
    if (needle_length_r > MAX_NEEDLE) begin
      len_c = LEN_W'(MAX_NEEDLE);
    end else begin
      len_c = LEN_W'(needle_length_r);
    end
  end

  // Handshake and pipeline control.
  logic in_acc;
  logic in_acc_byte;
  logic in_acc_load;
  logic out_valid_r;
  logic out_stall;
  logic s2_valid_r;
  logic s2_fire;
  logic sweep_active_r;
  logic sw_wr_r;

  assign out_stall   = out_valid_r && !out_ready;
  assign s2_fire     = s2_valid_r && !out_stall;
  assign in_ready    = !sweep_active_r && !sw_wr_r && !(s2_valid_r && out_stall);
  assign in_acc      = in_valid && in_ready;
  assign in_acc_byte = in_acc && (in_cmd == CMD_BYTE);
  assign in_acc_load = in_acc && (in_cmd == CMD_FOLD_LOAD);

  // Folded needle refresh after a needle write.
  logic [NI_W-1:0] sweep_cnt_r;
  logic [NI_W-1:0] sw_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_active_r <= 1'b0;
      sw_wr_r        <= 1'b0;
      sweep_cnt_r    <= '0;
      sw_idx_r       <= '0;
    end else begin
      sw_wr_r  <= sweep_active_r;
      sw_idx_r <= sweep_cnt_r;
      if (sweep_active_r) begin
        if (sweep_cnt_r == NI_W'(MAX_NEEDLE - 1)) begin
          sweep_active_r <= 1'b0;
        end else begin
          sweep_cnt_r <= sweep_cnt_r + 1'b1;
        end
      end
      if (cfg_we && ((cfg_index == CFG_NEEDLE_LOW) || (cfg_index == CFG_NEEDLE_HIGH))) begin
        sweep_active_r <= 1'b1;
        sweep_cnt_r    <= '0;
      end
    end
  end

  // Fold table.
  fold_rd_t   fold_rd;
  fold_wr_t   fold_wr;
  logic [7:0] fold_q;

  always_comb begin
    fold_rd.en   = sweep_active_r || in_acc_byte;
    fold_rd.addr = sweep_active_r ? raw_needle[sweep_cnt_r] : in_byte_value;
    fold_wr.en   = in_acc_load;
    fold_wr.addr = in_fold_index;
    fold_wr.data = in_byte_value;
  end

  bsws_fold_mem u_fold_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (fold_rd),
    .wr      (fold_wr),
    .rd_data (fold_q)
  );

  // Folded needle bytes, kept in step with table loads.
  logic [7:0] nf_r   [MAX_NEEDLE];
  logic [7:0] nf_nxt [MAX_NEEDLE];

  always_comb begin
    nf_nxt = nf_r;
    if (sw_wr_r) begin
      nf_nxt[sw_idx_r] = fold_q;
    end
    if (in_acc_load) begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        if (raw_needle[k] == in_fold_index) begin
          nf_nxt[k] = in_byte_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        nf_r[k] <= 8'h00;
      end
    end else begin
      nf_r <= nf_nxt;
    end
  end

  // Compare stage.
  logic [7:0] s2_byte_r;
  logic       s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!(s2_valid_r && out_stall)) begin
      s2_valid_r <= in_acc_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc_byte) begin
      s2_byte_r <= in_byte_value;
      s2_last_r <= in_is_last;
    end
  end

  // Window of recent bytes, newest at index 0, raw and folded.
  logic [7:0] win_r    [MAX_NEEDLE];
  logic [7:0] fwin_r   [MAX_NEEDLE];
  logic [7:0] win_nxt  [MAX_NEEDLE];
  logic [7:0] fwin_nxt [MAX_NEEDLE];
  logic [7:0] pw       [MAX_NEEDLE];
  logic [7:0] ns       [MAX_NEEDLE];
  logic [7:0] al       [MAX_NEEDLE];
  logic [7:0] left_byte;
  logic       match;
  logic       shift;

  always_comb begin
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      ns[k] = case_sensitive_r ? raw_needle[k] : nf_r[k];
    end
    // Needle byte len-1-j lines up with window position j.
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      al[j] = 8'h00;
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        if (int'(len_c) == j + k + 1) begin
          al[j] = ns[k];
        end
      end
    end
    pw[0] = case_sensitive_r ? s2_byte_r : fold_q;
    for (int j = 1; j < MAX_NEEDLE; j++) begin
      pw[j] = case_sensitive_r ? win_r[j-1] : fwin_r[j-1];
    end
    match = 1'b1;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      if ((j < int'(len_c)) && (pw[j] != al[j])) begin
        match = 1'b0;
      end
    end
    left_byte = s2_byte_r;
    for (int j = 1; j <= MAX_NEEDLE; j++) begin
      if (int'(len_c) == j) begin
        left_byte = win_r[j-1];
      end
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fwin_nxt = fwin_r;
    if (shift) begin
      win_nxt[0]  = s2_byte_r;
      fwin_nxt[0] = fold_q;
      for (int j = 1; j < MAX_NEEDLE; j++) begin
        win_nxt[j]  = win_r[j-1];
        fwin_nxt[j] = fwin_r[j-1];
      end
    end
    // A table load re-folds every window byte that uses the loaded entry.
    if (in_acc_load) begin
      for (int j = 0; j < MAX_NEEDLE; j++) begin
        if (win_nxt[j] == in_fold_index) begin
          fwin_nxt[j] = in_byte_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    fwin_r <= fwin_nxt;
  end

  // Search state.
  logic [OFFSET_BITS-1:0] byte_count_r;
  logic [OFFSET_BITS-1:0] byte_count_nxt;
  logic                   done_r;
  logic                   done_nxt;
  logic                   pend_r;
  logic                   pend_nxt;
  logic [OFFSET_BITS-1:0] pend_off_r;
  logic [OFFSET_BITS-1:0] pend_off_nxt;
  logic [OFFSET_BITS:0]   pos_plus1;
  logic [OFFSET_BITS-1:0] start_off;
  logic                   reach;
  logic                   left_ok;
  logic                   emit;
  logic                   found_v;
  logic [OFFSET_BITS-1:0] off_v;

  assign pos_plus1 = {1'b0, byte_count_r} + 1'b1;
  assign reach     = pos_plus1 >= (OFFSET_BITS+1)'(len_c);
  assign start_off = OFFSET_BITS'(pos_plus1 - (OFFSET_BITS+1)'(len_c));
  assign left_ok   = (start_off == '0) || !is_word_byte(left_byte);

  always_comb begin
    emit           = 1'b0;
    found_v        = 1'b0;
    off_v          = '0;
    shift          = 1'b0;
    done_nxt       = done_r;
    pend_nxt       = pend_r;
    pend_off_nxt   = pend_off_r;
    byte_count_nxt = byte_count_r;
    if (s2_fire) begin
      if (!done_r) begin
        shift = 1'b1;
        if (len_c == '0) begin
          emit    = 1'b1;
          found_v = 1'b1;
        end else begin
          // A pending hit is confirmed when this byte closes the word.
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (!is_word_byte(s2_byte_r)) begin
              emit    = 1'b1;
              found_v = 1'b1;
              off_v   = pend_off_r;
            end
          end
          if (!emit && reach && match) begin
            if (!whole_words_r || (left_ok && s2_last_r)) begin
              emit    = 1'b1;
              found_v = 1'b1;
              off_v   = start_off;
            end else if (left_ok) begin
              pend_nxt     = 1'b1;
              pend_off_nxt = start_off;
            end
          end
        end
        if (emit) begin
          done_nxt = 1'b1;
        end
        if (byte_count_r != '1) begin
          byte_count_nxt = byte_count_r + 1'b1;
        end
        if (s2_last_r && !emit) begin
          emit = 1'b1;
        end
      end
      if (s2_last_r) begin
        byte_count_nxt = '0;
        done_nxt       = 1'b0;
        pend_nxt       = 1'b0;
        pend_off_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      done_r       <= 1'b0;
      pend_r       <= 1'b0;
      pend_off_r   <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      done_r       <= done_nxt;
      pend_r       <= pend_nxt;
      pend_off_r   <= pend_off_nxt;
    end
  end

  // Result register; offsets clamp to the 32-bit port.
  logic [EXT_W-1:0] off_ext;
  logic             off_sat;
  logic [31:0]      off32;

  assign off_ext = EXT_W'(off_v);
  assign off_sat = |(off_ext >> 32);
  assign off32   = off_sat ? 32'hFFFF_FFFF : off_ext[31:0];

  logic        out_found_r;
  logic [31:0] out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r  <= found_v;
      out_offset_r <= found_v ? off32 : 32'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  // Checks.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_offset_r == 32'd0))
    else $error("not-found word carries a nonzero offset");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_last_r) |=> (!done_r && !pend_r && (byte_count_r == '0)))
    else $error("content end did not clear the search state");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && out_stall) |=> (s2_valid_r && $stable(s2_byte_r)))
    else $error("compare stage moved while the result was stalled");

endmodule
